@@ src/bpa_pkg.sv @@
`default_nettype none
package bpa_pkg;

  localparam int PAGE_COUNT  = 4096;
  localparam int ORDER_COUNT = 10;
  localparam int PG_W        = 12;
  localparam int LK_W        = 13;
  localparam int ORD_W       = 4;
  localparam int CNT_W       = 13;
  localparam int PAIR_W      = ORDER_COUNT - 1;
  localparam int SLOT_W      = PG_W - 1;

  localparam logic [LK_W-1:0] LINK_NONE = LK_W'(PAGE_COUNT);

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NOBLK  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic clr;
    logic load;
    logic init_cur;
    logic cur_inc;
    logic cur_dec;
    logic take_head;
    logic link_rd_pg;
    logic link_rd_buddy;
    logic pair_rd;
    logic pair_wr;
    logic unlink;
    logic push_a;
    logic push_b;
    logic pg_add;
    logic merge_step;
    logic cnt_sub;
    logic cnt_add;
    logic set_nob;
    logic set_rej;
    logic set_grant;
    logic out_load;
  } cmd_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic clr_done;
    logic req_mode;
    logic alloc_ok;
    logic free_ok;
    logic head_valid;
    logic cur_top;
    logic cur_gt_req;
    logic can_merge;
    logic pair_was;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ src/bpa_dp.sv @@
`default_nettype none
module bpa_dp (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [bpa_pkg::CNT_W-1:0] cfg_wdata,
  input  wire logic                     in_mode,
  input  wire logic [bpa_pkg::ORD_W-1:0] in_block_order,
  input  wire logic [bpa_pkg::PG_W-1:0]  in_page_index,
  input  wire bpa_pkg::cmd_t            cmd,
  output bpa_pkg::sts_t                 sts,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [bpa_pkg::PG_W-1:0]       out_granted_index,
  output logic [bpa_pkg::CNT_W-1:0]      out_free_total
);
  import bpa_pkg::*;

  logic [CNT_W-1:0]  wm_r;
  logic              req_mode_r;
  logic [ORD_W-1:0]  req_ord_r;
  logic [PG_W-1:0]   req_idx_r;
  logic [ORD_W-1:0]  cur_r;
  logic [PG_W-1:0]   pg_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [LK_W-1:0]   head_r [ORDER_COUNT];
  logic [LK_W-1:0]   lk_next_r, lk_prev_r;
  logic [PAIR_W-1:0] pair_rd_r;
  logic [SLOT_W-1:0] clr_r;
  logic [1:0]        res_st_r;
  logic [PG_W-1:0]   res_gr_r;
  logic              out_valid_r;
  logic [1:0]        out_st_r;
  logic [PG_W-1:0]   out_gr_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [LK_W-1:0]   next_mem [PAGE_COUNT];
  logic [LK_W-1:0]   prev_mem [PAGE_COUNT];
  logic [PAIR_W-1:0] pair_mem [PAGE_COUNT/2];

  logic [LK_W-1:0]   head_cur, pv, nx;
  logic [PG_W-1:0]   buddy, lk_addr;
  logic [SLOT_W-1:0] slot, pair_addr;
  logic [PAIR_W-1:0] pair_sh, pair_data;
  logic              pair_we;
  logic              nx_we, pv_we;
  logic [PG_W-1:0]   nx_addr, pv_addr;
  logic [LK_W-1:0]   nx_data, pv_data;
  logic [CNT_W:0]    need, sum;
  logic [CNT_W-1:0]  blk;

  always_comb begin
    head_cur = (cur_r < ORD_W'(ORDER_COUNT)) ? head_r[cur_r] : LINK_NONE;
    buddy    = pg_r ^ (PG_W'(1) << cur_r);
    lk_addr  = cmd.link_rd_buddy ? buddy : pg_r;
    pv       = lk_prev_r;
    nx       = (lk_next_r > LINK_NONE) ? LINK_NONE : lk_next_r;
    slot     = SLOT_W'(pg_r >> ({1'b0, cur_r} + 5'd1));
    pair_sh  = pair_rd_r >> cur_r;
    pair_we  = cmd.clr || (cmd.pair_wr && cur_r < ORD_W'(PAIR_W));
    pair_addr = cmd.clr ? clr_r : slot;
    pair_data = cmd.clr ? '0 : (pair_rd_r ^ (PAIR_W'(1) << cur_r));

    nx_we = 1'b0; nx_addr = pg_r; nx_data = head_cur;
    if (cmd.unlink && pv < LINK_NONE) begin
      nx_we = 1'b1; nx_addr = pv[PG_W-1:0]; nx_data = nx;
    end else if (cmd.push_a) begin
      nx_we = 1'b1;
    end

    pv_we = 1'b0; pv_addr = pg_r; pv_data = LINK_NONE;
    if (cmd.unlink && nx < LINK_NONE) begin
      pv_we = 1'b1; pv_addr = nx[PG_W-1:0];
      pv_data = (pv < LINK_NONE) ? pv : LINK_NONE;
    end else if (cmd.push_a) begin
      pv_we = 1'b1;
    end else if (cmd.push_b && head_cur < LINK_NONE) begin
      pv_we = 1'b1; pv_addr = head_cur[PG_W-1:0]; pv_data = {1'b0, pg_r};
    end

    blk  = CNT_W'(1) << req_ord_r;
    need = {1'b0, wm_r} + {1'b0, blk};
    sum  = {1'b0, cnt_r} + {1'b0, blk};

    sts.clr_done   = (clr_r == '1);
    sts.req_mode   = req_mode_r;
    sts.alloc_ok   = (req_ord_r < ORD_W'(ORDER_COUNT)) && ({1'b0, cnt_r} > need);
    sts.free_ok    = (req_ord_r < ORD_W'(ORDER_COUNT))
                     && ((req_idx_r & ~(PG_W'('1) << req_ord_r)) == '0)
                     && (({1'b0, req_idx_r} + blk) <= CNT_W'(PAGE_COUNT));
    sts.head_valid = head_cur < LINK_NONE;
    sts.cur_top    = cur_r >= ORD_W'(ORDER_COUNT);
    sts.cur_gt_req = cur_r > req_ord_r;
    sts.can_merge  = ({1'b0, cur_r} + 5'd1) < 5'(ORDER_COUNT);
    sts.pair_was   = pair_sh[0];
    sts.out_free   = !out_valid_r || out_ready;
  end

  // memories
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_addr] <= nx_data;
    if (pv_we) prev_mem[pv_addr] <= pv_data;
    if (pair_we) pair_mem[pair_addr] <= pair_data;
    if (cmd.link_rd_pg || cmd.link_rd_buddy) begin
      lk_next_r <= next_mem[lk_addr];
      lk_prev_r <= prev_mem[lk_addr];
    end
    if (cmd.pair_rd) pair_rd_r <= pair_mem[slot];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r <= in_mode;
      req_ord_r  <= in_block_order;
      req_idx_r  <= in_page_index;
      res_st_r   <= ST_DONE;
      res_gr_r   <= '0;
    end
    if (cmd.set_nob)   res_st_r <= ST_NOBLK;
    if (cmd.set_rej)   res_st_r <= ST_REJECT;
    if (cmd.set_grant) res_gr_r <= pg_r;
    if (cmd.init_cur) begin
      cur_r <= req_ord_r;
      pg_r  <= req_idx_r;
    end
    if (cmd.cur_inc)   cur_r <= cur_r + 1'b1;
    if (cmd.cur_dec)   cur_r <= cur_r - 1'b1;
    if (cmd.take_head) pg_r  <= head_cur[PG_W-1:0];
    if (cmd.pg_add)    pg_r  <= pg_r + (PG_W'(1) << cur_r);
    if (cmd.merge_step) begin
      cur_r <= cur_r + 1'b1;
      pg_r  <= pg_r & (PG_W'('1) << ({1'b0, cur_r} + 5'd1));
    end
    if (cmd.out_load) begin
      out_st_r  <= res_st_r;
      out_gr_r  <= res_gr_r;
      out_cnt_r <= cnt_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm_r        <= '0;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ORDER_COUNT; i++) head_r[i] <= LINK_NONE;
    end else begin
      if (cfg_we) wm_r <= cfg_wdata;
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.cnt_sub) cnt_r <= cnt_r - blk;
      if (cmd.cnt_add) cnt_r <= (sum > (CNT_W+1)'(PAGE_COUNT)) ? CNT_W'(PAGE_COUNT)
                                                              : sum[CNT_W-1:0];
      for (int i = 0; i < ORDER_COUNT; i++) begin
        if (ORD_W'(i) == cur_r) begin
          if (cmd.unlink && pv >= LINK_NONE) head_r[i] <= nx;
          if (cmd.push_b) head_r[i] <= {1'b0, pg_r};
        end
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_st_r;
  assign out_granted_index = out_gr_r;
  assign out_free_total    = out_cnt_r;

endmodule
`default_nettype wire

@@ src/bpa_ctl.sv @@
`default_nettype none
module bpa_ctl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  output logic               in_ready,
  input  wire bpa_pkg::sts_t sts,
  output bpa_pkg::cmd_t      cmd
);
  import bpa_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0,  S_IDLE = 4'd1,  S_ACHK = 4'd2,
                         S_SCAN = 4'd3,  S_ARD  = 4'd4,  S_AWR  = 4'd5,
                         S_SPL  = 4'd6,  S_P1   = 4'd7,  S_P2   = 4'd8,
                         S_FCHK = 4'd9,  S_FLP  = 4'd10, S_FPW  = 4'd11,
                         S_FUW  = 4'd12, S_DONE = 4'd13;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_mode ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts.alloc_ok) begin
          cmd.init_cur = 1'b1; state_nxt = S_SCAN;
        end else begin
          cmd.set_nob = 1'b1; state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (sts.cur_top) begin
          cmd.set_nob = 1'b1; state_nxt = S_DONE;
        end else if (sts.head_valid) begin
          cmd.take_head = 1'b1; state_nxt = S_ARD;
        end else begin
          cmd.cur_inc = 1'b1;
        end
      end
      S_ARD: begin
        cmd.link_rd_pg = 1'b1; cmd.pair_rd = 1'b1; state_nxt = S_AWR;
      end
      S_AWR: begin
        cmd.unlink = 1'b1; cmd.pair_wr = 1'b1; cmd.cnt_sub = 1'b1;
        state_nxt = S_SPL;
      end
      S_SPL: begin
        if (sts.cur_gt_req) begin
          cmd.cur_dec = 1'b1; state_nxt = S_P1;
        end else begin
          cmd.set_grant = 1'b1; state_nxt = S_DONE;
        end
      end
      S_P1: begin
        cmd.push_a = 1'b1; cmd.pair_rd = 1'b1; state_nxt = S_P2;
      end
      S_P2: begin
        cmd.push_b = 1'b1;
        if (sts.req_mode) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pair_wr = 1'b1; cmd.pg_add = 1'b1; state_nxt = S_SPL;
        end
      end
      S_FCHK: begin
        if (sts.free_ok) begin
          cmd.init_cur = 1'b1; cmd.cnt_add = 1'b1; state_nxt = S_FLP;
        end else begin
          cmd.set_rej = 1'b1; state_nxt = S_DONE;
        end
      end
      S_FLP: begin
        if (sts.can_merge) begin
          cmd.pair_rd = 1'b1; state_nxt = S_FPW;
        end else begin
          state_nxt = S_P1;
        end
      end
      S_FPW: begin
        cmd.pair_wr = 1'b1;
        if (sts.pair_was) begin
          cmd.link_rd_buddy = 1'b1; state_nxt = S_FUW;
        end else begin
          state_nxt = S_P1;
        end
      end
      S_FUW: begin
        cmd.unlink = 1'b1; cmd.merge_step = 1'b1; state_nxt = S_FLP;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

@@ src/buddy_page_allocator.sv @@
`default_nettype none
// Channel   Handshake            Payload
// in        in_valid/in_ready    in_mode, in_block_order, in_page_index
// out       out_valid/out_ready  out_status, out_granted_index, out_free_total
// cfg       cfg_we               cfg_wdata (low watermark)
//
// One item at a time through a state sequencer over link and pair-bit memories.
// Allocate: checks the free count against the low watermark, scans the orders upward
// from the requested one for a listed block, then splits it down one order per level;
// it ends with no block when every list from that order up is empty. Free: checks
// alignment and range, then merges with the free buddy one order per level.
// After reset a clearing pass zeroes all 2048 pair-bit words; no item is
// taken meanwhile. A result waits in the output register while the next item
// is taken; the sequencer holds in its final state only if that register is full.
module buddy_page_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [12:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [3:0]  in_block_order,
  input  wire logic [11:0] in_page_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [11:0]      out_granted_index,
  output logic [12:0]      out_free_total
);
  import bpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the state and the input handshake
  bpa_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: lists, pair bits, counters and the output register
  bpa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_mode),
    .in_block_order    (in_block_order),
    .in_page_index     (in_page_index),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_total    (out_free_total)
  );

  // a refused or rejected item never carries a granted page
  a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_granted_index == '0)
    else $error("granted index on a failed item");

  // the free count never passes the zone size
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_free_total <= 13'(PAGE_COUNT))
    else $error("free total beyond zone size");

  // one item in flight: no transfer in straight after a transfer in
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

endmodule
`default_nettype wire
